// File: rtl/secded_pkg.sv
`default_nettype none

package secded_pkg;

   localparam int DataBits  = 64;
   localparam int CheckBits = 8;
   localparam int WidthBits = 7;
   localparam int EwBits    = 4;
   localparam int PosBits   = 7;
   localparam int TableLen  = 72;
   localparam int MaskCount = 7;

   typedef enum logic {
      OP_ENCODE = 1'b0,
      OP_CHECK  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_NONE          = 2'd0,
      STATUS_SINGLE        = 2'd1,
      STATUS_UNCORRECTABLE = 2'd2
   } status_type;

   typedef struct packed {
      opcode_type            opcode;
      logic [DataBits-1:0]   data_word;
      logic [CheckBits-1:0]  check_bits;
   } req_type;

   typedef struct packed {
      logic [CheckBits-1:0]  code_bits;
      status_type            status;
      logic [PosBits-1:0]    error_position;
   } rsp_type;

   typedef struct packed {
      logic [WidthBits-1:0]  data_width;
      logic [EwBits-1:0]     check_width;
   } cfg_type;

   localparam logic [DataBits-1:0] ParityMask [MaskCount] = '{
      64'hab55555556aaad5b,
      64'hcd9999999b33366d,
      64'hf1e1e1e1e3c3c78e,
      64'h01fe01fe03fc07f0,
      64'h01fffe0003fff800,
      64'h01fffffffc000000,
      64'hfe00000000000000
   };

   // zero: no flip; negative -k: check bit k-1; positive p: data bit position p
   localparam logic signed [7:0] PosTable [TableLen] = '{
       8'sd0,  -8'sd1,  -8'sd2,  8'sd1, -8'sd3,  8'sd2,  8'sd3,  8'sd4,
      -8'sd4,  8'sd5,  8'sd6,  8'sd7,  8'sd8,  8'sd9,  8'sd10, 8'sd11,
      -8'sd5,  8'sd12, 8'sd13, 8'sd14, 8'sd15, 8'sd16, 8'sd17, 8'sd18,
       8'sd19, 8'sd20, 8'sd21, 8'sd22, 8'sd23, 8'sd24, 8'sd25, 8'sd26,
      -8'sd6,  8'sd27, 8'sd28, 8'sd29, 8'sd30, 8'sd31, 8'sd32, 8'sd33,
       8'sd34, 8'sd35, 8'sd36, 8'sd37, 8'sd38, 8'sd39, 8'sd40, 8'sd41,
       8'sd42, 8'sd43, 8'sd44, 8'sd45, 8'sd46, 8'sd47, 8'sd48, 8'sd49,
       8'sd50, 8'sd51, 8'sd52, 8'sd53, 8'sd54, 8'sd55, 8'sd56, 8'sd57,
      -8'sd7,  8'sd58, 8'sd59, 8'sd60, 8'sd61, 8'sd62, 8'sd63, 8'sd64
   };

   localparam logic [WidthBits-1:0] WidthMin   = 7'd1;
   localparam logic [WidthBits-1:0] WidthMax   = 7'd64;
   localparam logic [WidthBits-1:0] WidthReset = 7'd64;
   localparam logic [EwBits-1:0]    EwReset    = 4'd8;

   // clamp a raw width into 1..64
   function automatic logic [WidthBits-1:0] clamp_width(input logic [WidthBits-1:0] raw);
      logic [WidthBits-1:0] w;
      w = raw;
      if (raw < WidthMin) w = WidthMin;
      if (raw > WidthMax) w = WidthMax;
      return w;
   endfunction

   // Hamming bits for the width plus one overall parity bit
   function automatic logic [EwBits-1:0] check_width_of(input logic [WidthBits-1:0] dw);
      int e;
      e = 0;
      for (int k = 0; k < 8; k++) begin
         if ((1 << e) < int'(dw) + 1) e++;
      end
      if (e + int'(dw) >= (1 << e)) e++;
      return EwBits'(e + 1);
   endfunction

endpackage

`default_nettype wire

// File: rtl/secded_codec.sv
`default_nettype none

module secded_codec (
   input  wire secded_pkg::cfg_type cfg,
   input  wire secded_pkg::req_type req,
   output secded_pkg::rsp_type      rsp
);
   import secded_pkg::*;

   logic [MaskCount-1:0]  low_enable;
   logic [MaskCount-1:0]  low_parity;
   logic [CheckBits-1:0]  code;
   logic [2:0]            top_index;
   logic                  overall;
   logic                  rx_parity;
   logic [MaskCount-1:0]  syndrome;
   logic signed [7:0]     entry;
   logic [PosBits-1:0]    neg_entry;

   always_comb begin
      for (int i = 0; i < MaskCount; i++) begin
         low_enable[i] = (i < int'(cfg.check_width) - 1);
         low_parity[i] = low_enable[i] & (^(req.data_word & ParityMask[i]));
      end
      overall   = (^low_parity) ^ (^req.data_word);
      top_index = 3'(cfg.check_width - 4'd1);
      code = {1'b0, low_parity};
      code[top_index] = overall;
   end

   always_comb begin
      rx_parity = (^req.check_bits) ^ (^req.data_word);
      syndrome  = (req.check_bits[MaskCount-1:0] ^ code[MaskCount-1:0]) & low_enable;
      entry     = (int'(syndrome) < TableLen) ? PosTable[syndrome] : 8'sd0;
      neg_entry = PosBits'(-entry);

      rsp.code_bits      = code;
      rsp.status         = STATUS_NONE;
      rsp.error_position = '0;
      if (req.opcode == OP_CHECK) begin
         if (int'(syndrome) >= TableLen) begin
            rsp.status = STATUS_UNCORRECTABLE;
         end else if (!rx_parity) begin
            rsp.status = (entry == 8'sd0) ? STATUS_NONE : STATUS_UNCORRECTABLE;
         end else begin
            rsp.status = STATUS_SINGLE;
            if (entry == 8'sd0) begin
               rsp.error_position = cfg.data_width + PosBits'(cfg.check_width);
            end else if (entry < 8'sd0) begin
               rsp.error_position = cfg.data_width + neg_entry;
            end else begin
               rsp.error_position = PosBits'(entry);
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/secded_ecc_encode_decode.sv
// A request taken into the input register moves on to the result register, where
// rsp_strobe is high for a single cycle with its result.
// Throughput: one request every cycle; the whole parity and table pass fits between the
// input register and the result register, so busy stays low.
// The receiver cannot stall, so no result is ever held back.
// Synchronous reset clears the valid flags and sets the data width to 64 (check width 8).
`default_nettype none

module secded_ecc_encode_decode (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  wire secded_pkg::req_type req_payload,
   output logic                 rsp_strobe,
   output secded_pkg::rsp_type  rsp_payload,
   input  wire                  csr_write_enable,
   input  wire [6:0]            csr_write_data
);
   import secded_pkg::*;

   // configuration: clamped width and its check width, worked out at write time
   cfg_type cfg_ff, cfg_in;

   // input stage
   logic    req_valid_ff, req_valid_in;
   req_type req_ff;

   // result stage
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_result;

   // Never stall: a request can enter every cycle
   assign busy = 1'b0;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         cfg_in.data_width  = clamp_width(csr_write_data);
         cfg_in.check_width = check_width_of(clamp_width(csr_write_data));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.data_width  <= WidthReset;
         cfg_ff.check_width <= EwReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Capture the request; payload needs no reset
   assign req_valid_in = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_payload;
      end
   end

   // Encode, recompute syndrome and look up the position in one pass
   secded_codec u_codec (
      .cfg (cfg_ff),
      .req (req_ff),
      .rsp (rsp_result)
   );

   // Advance into the result register; strobe for one cycle only
   assign rsp_valid_in = req_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_ff <= rsp_result;
      end
   end

   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // An encode request never reports an error
   assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && (req_ff.opcode == OP_ENCODE) |=>
         (rsp_payload.status == STATUS_NONE) && (rsp_payload.error_position == '0))
      else $error("encode result carries an error report");

   // A strobe follows in the cycle after a request is held in the input stage
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == $past(req_valid_ff))
      else $error("result strobe out of step with input stage");

   // Only a single-error result carries a position
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_payload.status != STATUS_SINGLE) |-> rsp_payload.error_position == '0)
      else $error("position reported without a single error");

   // A single-error result always names a position
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_payload.status == STATUS_SINGLE) |-> rsp_payload.error_position != '0)
      else $error("single error reported without a position");

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import secded_pkg::*;

   // Clock, reset and the block's ports; every input starts at a known value
   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_payload = '0;
   logic        rsp_strobe;
   rsp_type     rsp_payload;
   logic        csr_write_enable = 1'b0;
   logic [6:0]  csr_write_data = '0;

   // Requests waiting for the driver, and the results still owed by the block
   req_type     request_queue[$];
   rsp_type     due_results[$];

   // Raw width code last written to the block; reset value is 64
   logic [6:0]  width_cfg = WidthReset;
   // Chance, in percent, that the driver leaves a cycle empty
   int          idle_pct = 0;
   // Set at each rising edge when the request on the port was taken
   bit          req_taken = 1'b0;
   int          mismatches = 0;

   // Widths to visit: both ends, the out-of-range codes and the points where
   // the check width steps up or down
   logic [6:0]  width_plan[13] = '{7'd1, 7'd0, 7'd127, 7'd2, 7'd4, 7'd11, 7'd12,
                                   7'd26, 7'd57, 7'd58, 7'd63, 7'd64, 7'd100};
   int          idle_modes[3] = '{88, 6, 0};

   secded_ecc_encode_decode DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_payload      (req_payload),
      .rsp_strobe       (rsp_strobe),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Width codes 0 and 65..127 fold onto the nearest legal width
   function automatic int effective_width(logic [6:0] raw);
      if (raw == 7'd0) return 1;
      if (raw > 7'd64) return 64;
      return int'(raw);
   endfunction

   // Number of check bits: Hamming bits for the width plus the overall parity bit
   function automatic int ecc_bits(int dw);
      int h;
      h = 0;
      while ((1 << h) < dw + 1) h++;
      if (h + dw >= (1 << h)) h++;
      return h + 1;
   endfunction

   function automatic rsp_type secded_predict(req_type rq, logic [6:0] width_raw);
      rsp_type    r;
      int         dw;
      int         ew;
      int         syn;
      logic [7:0] code;
      logic       par;
      dw   = effective_width(width_raw);
      ew   = ecc_bits(dw);
      code = '0;
      for (int i = 0; i < ew - 1; i++)
         code[i] = ^(rq.data_word & ParityMask[i]);
      // Top check bit evens out the parity over check bits and the whole data word
      code[ew-1] = ^code ^ ^rq.data_word;
      r.code_bits      = code;
      r.status         = STATUS_NONE;
      r.error_position = '0;
      if (rq.opcode == OP_CHECK) begin
         // All eight received check bits count, even those above the check width
         par = ^rq.check_bits ^ ^rq.data_word;
         syn = int'((rq.check_bits ^ code) & ((8'd1 << (ew - 1)) - 8'd1));
         if (syn >= TableLen) begin
            r.status = STATUS_UNCORRECTABLE;
         end else if (!par) begin
            r.status = (syn == 0) ? STATUS_NONE : STATUS_UNCORRECTABLE;
         end else begin
            r.status = STATUS_SINGLE;
            if (syn == 0) begin
               // Only the overall parity bit is wrong
               r.error_position = 7'(dw + ew);
            end else if ((syn & (syn - 1)) == 0) begin
               // Powers of two name the Hamming check bits
               r.error_position = 7'(dw + $clog2(syn) + 1);
            end else begin
               // Data bits fill the remaining syndromes in order
               r.error_position = 7'(syn - $clog2(syn + 1));
            end
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // A check request carrying the correct check bits for the data
   function automatic req_type clean_codeword(logic [63:0] data);
      req_type rq;
      rsp_type enc;
      rq.opcode     = OP_ENCODE;
      rq.data_word  = data;
      rq.check_bits = '0;
      enc = secded_predict(rq, width_cfg);
      rq.opcode     = OP_CHECK;
      rq.check_bits = enc.code_bits;
      return rq;
   endfunction

   // Bit numbers 0..63 are data bits, 64..71 are check bits 0..7
   function automatic req_type flip_bit(req_type rq, int idx);
      if (idx < 64) rq.data_word[idx] = ~rq.data_word[idx];
      else          rq.check_bits[idx-64] = ~rq.check_bits[idx-64];
      return rq;
   endfunction

   // Flip distinct bits of a clean codeword; stray picks may land on data bits
   // above the width or check bits above the check width
   function automatic req_type codeword_with_flips(logic [63:0] data, int flips, bit stray);
      req_type     rq;
      logic [71:0] used;
      int          dw;
      int          ew;
      int          idx;
      rq   = clean_codeword(data);
      dw   = effective_width(width_cfg);
      ew   = ecc_bits(dw);
      used = '0;
      repeat (flips) begin
         do begin
            if (stray) begin
               idx = $urandom_range(71);
            end else begin
               idx = $urandom_range(dw + ew - 1);
               if (idx >= dw) idx = idx - dw + 64;
            end
         end while (used[idx]);
         used[idx] = 1'b1;
         rq = flip_bit(rq, idx);
      end
      return rq;
   endfunction

   function automatic logic [63:0] random_word();
      case ($urandom_range(4))
         0: return 64'($urandom_range(15));
         1: return ~(64'd1 << $urandom_range(63));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic push_encode(logic [63:0] data, logic [7:0] junk);
      req_type rq;
      rq.opcode     = OP_ENCODE;
      rq.data_word  = data;
      rq.check_bits = junk;
      request_queue.push_back(rq);
   endtask

   task automatic push_raw_check(logic [63:0] data, logic [7:0] check);
      req_type rq;
      rq.opcode     = OP_CHECK;
      rq.data_word  = data;
      rq.check_bits = check;
      request_queue.push_back(rq);
   endtask

   task automatic push_random_request();
      int pick;
      int flips;
      pick  = $urandom_range(99);
      flips = $urandom_range(99);
      if (pick < 15) begin
         push_encode(random_word(), 8'($urandom));
      end else if (pick < 25) begin
         // noise: arbitrary data against arbitrary check bits
         push_raw_check(random_word(), 8'($urandom));
      end else begin
         flips = (flips < 25) ? 0 : (flips < 70) ? 1 : (flips < 90) ? 2 : 3;
         request_queue.push_back(codeword_with_flips(random_word(), flips,
                                                     $urandom_range(4) == 0));
      end
   endtask

   // Width 64 straight after reset: field extremes, both operations, every
   // decode outcome
   task automatic push_directed();
      logic [63:0] ones;
      ones = ~64'd0;
      push_encode(64'd0, 8'd0);
      push_encode(ones, 8'hFF);
      push_encode(64'h8000_0000_0000_0001, 8'h00);
      push_encode(64'h5555_5555_5555_5555, 8'hAA);
      request_queue.push_back(clean_codeword(64'd0));
      request_queue.push_back(clean_codeword(ones));
      request_queue.push_back(flip_bit(clean_codeword(ones), 0));
      request_queue.push_back(flip_bit(clean_codeword(64'd0), 63));
      request_queue.push_back(flip_bit(clean_codeword(64'h1234_5678_9ABC_DEF0), 64));
      request_queue.push_back(flip_bit(clean_codeword(64'hFEDC_BA98_7654_3210), 70));
      // overall parity bit alone: odd parity, zero syndrome
      request_queue.push_back(flip_bit(clean_codeword(64'hDEAD_BEEF_0000_FFFF), 71));
      // double error: even parity, nonzero syndrome
      request_queue.push_back(flip_bit(flip_bit(clean_codeword(ones), 5), 40));
      // syndromes past the end of the position table, odd and even parity
      push_raw_check(64'd0, 8'h7F);
      push_raw_check(64'd0, 8'h48);
      push_raw_check(64'd0, 8'hFF);
      push_raw_check(ones, 8'h00);
   endtask

   // Per width: flips of check bit 7 and data bit 63, a clean check, an encode
   task automatic push_width_corners();
      logic [63:0] data;
      data = random_word();
      request_queue.push_back(flip_bit(clean_codeword(data), 71));
      request_queue.push_back(flip_bit(clean_codeword(data), 63));
      request_queue.push_back(clean_codeword(data));
      push_encode(data, 8'($urandom));
   endtask

   // Hold until the driver has nothing left and every result is back
   task automatic wait_idle();
      while (request_queue.size() != 0 || due_results.size() != 0 || start)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_width(logic [6:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      width_cfg = value;
   endtask

   task automatic report_mismatch(string what, rsp_type want, rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t mismatch (%s): expected %h/%0d/%0d, got %h/%0d/%0d",
                  $realtime, what, want.code_bits, want.status, want.error_position,
                  got.code_bits, got.status, got.error_position);
   endtask

   // ------------------------------------------------------------------
   // Driver: change inputs on the falling edge
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         // Port is free: present the next request unless this cycle stays idle
         if (request_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
            start       <= 1'b1;
            req_payload <= request_queue.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: sample on the rising edge, check results, predict new ones
   // ------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      rsp_type want;
      // Check the result leaving the block at this edge first
      if (!reset && rsp_strobe) begin
         if (due_results.size() == 0) begin
            report_mismatch("result with none expected", '0, rsp_payload);
         end else begin
            want = due_results.pop_front();
            if (rsp_payload.code_bits !== want.code_bits ||
                rsp_payload.status !== want.status ||
                rsp_payload.error_position !== want.error_position)
               report_mismatch("wrong field", want, rsp_payload);
         end
      end
      // Then log the request taken at this edge
      req_taken = !reset && start && !busy;
      if (req_taken)
         due_results.push_back(secded_predict(req_payload, width_cfg));
   end

   // ------------------------------------------------------------------
   // Sequence: reset, directed checks, then one random phase per width
   // ------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset width is 64; run the directed set without a register write
      push_directed();
      wait_idle();

      for (int p = 0; p < 14; p++) begin
         idle_pct = idle_modes[p % 3];
         write_width((p == 13) ? 7'($urandom_range(127)) : width_plan[p]);
         @(posedge clock);
         push_width_corners();
         repeat (68) push_random_request();
         // Drain fully mid-phase so the block sees a long pause
         wait_idle();
         repeat (67) push_random_request();
         wait_idle();
      end

      // Leave room for any stray late result
      repeat (8) @(posedge clock);
      if (due_results.size() != 0) mismatches++;
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: files.f
rtl/secded_pkg.sv
rtl/secded_codec.sv
rtl/secded_ecc_encode_decode.sv
tb/sv/tb_top.sv
